/* design/fram_pkg.sv */
// ----------------------------------------------------------------------------
// Fraction unit package
// Shared types, codes and defaults of the fraction reduce, add and multiply
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package fram_pkg;

  localparam int unsigned PART_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_MAKE = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_MUL  = 2'd2,
    CMD_NONE = 2'd3
  } fram_cmd_code_t;

  typedef enum logic [1:0] {
    MS_NUM   = 2'd0,
    MS_DEN   = 2'd1,
    MS_CROSS = 2'd2,
    MS_SPARE = 2'd3
  } fram_mstep_t;

  typedef enum logic [1:0] {
    RS_ZERO  = 2'd0,
    RS_ACC   = 2'd1,
    RS_QUO   = 2'd2,
    RS_SPARE = 2'd3
  } fram_rsel_t;

  typedef struct packed {
    logic        load;
    logic        mul_en;
    fram_mstep_t mul_step;
    logic        gcd_init;
    logic        gcd_step;
    logic        div_init;
    logic        div_step;
    logic        publish;
    fram_rsel_t  res_sel;
  } fram_ctl_t;

  typedef struct packed {
    logic make_ok;
    logic arith_ok;
    logic is_add;
    logic gcd_done;
  } fram_sts_t;

endpackage

`default_nettype wire

/* design/fram_in_if.sv */
// ----------------------------------------------------------------------------
// Fraction unit input channel
// Valid/ready channel carrying one command with its two operand fractions.
// ----------------------------------------------------------------------------
`default_nettype none

interface fram_in_if import fram_pkg::*; #(
  parameter int unsigned PW = PART_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [1:0]    command;
  logic [PW-1:0] a_num;
  logic [PW-1:0] a_den;
  logic          a_valid;
  logic [PW-1:0] b_num;
  logic [PW-1:0] b_den;
  logic          b_valid;

  modport source (
    output valid, command, a_num, a_den, a_valid, b_num, b_den, b_valid,
    input  ready
  );

  modport sink (
    input  valid, command, a_num, a_den, a_valid, b_num, b_den, b_valid,
    output ready
  );
endinterface

`default_nettype wire

/* design/fram_out_if.sv */
// ----------------------------------------------------------------------------
// Fraction unit result channel
// Valid/ready channel carrying one result fraction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fram_out_if import fram_pkg::*; #(
  parameter int unsigned PW = PART_WIDTH_DEF
);
  logic            valid;
  logic            ready;
  logic [2*PW:0]   res_num;
  logic [2*PW-1:0] res_den;
  logic            res_valid;

  modport source (
    output valid, res_num, res_den, res_valid,
    input  ready
  );

  modport sink (
    input  valid, res_num, res_den, res_valid,
    output ready
  );
endinterface

`default_nettype wire

/* design/fraction_reduce_add_multiply.sv */
// ----------------------------------------------------------------------------
// Fraction reduce, add and multiply unit
// Unsigned rational arithmetic: make with GCD reduction, add, multiply.
//
// The input channel carries one command with operands a and b; the result
// channel carries one fraction per accepted command, in order. Both use a
// valid/ready handshake and a transaction completes when both are high.
// Commands are processed one at a time. A result is registered for an
// invalid operand or unused command as well as for multiply and add,
// which use one shared multiplier over successive cycles. Make runs a
// binary GCD loop followed by a bit-serial division. A finished result
// sits in an output register; the next transaction is accepted while it
// waits, and a stalled receiver only holds the block once the following
// result is ready.
// Reset (synchronous, active low) returns the controller to idle and
// empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reduce_add_multiply import fram_pkg::*; #(
  parameter int unsigned PART_WIDTH = PART_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  fram_in_if.sink    in_ch,
  fram_out_if.source out_ch
);

  fram_ctl_t ctl;
  fram_sts_t sts;

  fram_ctrl #(
    .PW (PART_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fram_dp #(
    .PW (PART_WIDTH)
  ) u_dp (
    .clk           (clk),
    .in_command    (in_ch.command),
    .in_a_num      (in_ch.a_num),
    .in_a_den      (in_ch.a_den),
    .in_a_valid    (in_ch.a_valid),
    .in_b_num      (in_ch.b_num),
    .in_b_den      (in_ch.b_den),
    .in_b_valid    (in_ch.b_valid),
    .ctl           (ctl),
    .sts           (sts),
    .out_res_num   (out_ch.res_num),
    .out_res_den   (out_ch.res_den),
    .out_res_valid (out_ch.res_valid)
  );

endmodule

`default_nettype wire

/* design/fram_dp.sv */
// ----------------------------------------------------------------------------
// Fraction unit datapath
// Operand registers, shared multiplier with accumulator, binary GCD unit,
// two bit-serial dividers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fram_dp import fram_pkg::*; #(
  parameter int unsigned PW = PART_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic [1:0]      in_command,
  input  wire logic [PW-1:0]   in_a_num,
  input  wire logic [PW-1:0]   in_a_den,
  input  wire logic            in_a_valid,
  input  wire logic [PW-1:0]   in_b_num,
  input  wire logic [PW-1:0]   in_b_den,
  input  wire logic            in_b_valid,
  input  wire fram_ctl_t       ctl,
  output fram_sts_t            sts,
  output logic      [2*PW:0]   out_res_num,
  output logic      [2*PW-1:0] out_res_den,
  output logic                 out_res_valid
);

  localparam int unsigned KW = $clog2(PW);

  logic [1:0]      cmd_r;
  logic [PW-1:0]   an_r, ad_r, bn_r, bd_r;
  logic            av_r, bv_r;
  logic [2*PW:0]   acc_num_r;
  logic [2*PW-1:0] acc_den_r;
  logic [PW-1:0]   gp_r, gq_r;
  logic [KW-1:0]   gk_r;
  logic [PW-1:0]   dv_r, qa_r, qd_r, ra_r, rd_r;
  logic [2*PW:0]   res_num_r;
  logic [2*PW-1:0] res_den_r;
  logic            res_valid_r;

  logic [PW-1:0]   mop_a, mop_b;
  logic [2*PW-1:0] prod;
  logic [PW-1:0]   gp_nxt, gq_nxt, g_val;
  logic [KW-1:0]   gk_nxt;
  logic [PW:0]     ta, td;
  logic            bit_a, bit_d;

  assign sts.make_ok  = (cmd_r == CMD_MAKE) && av_r && (ad_r != '0);
  assign sts.arith_ok = ((cmd_r == CMD_ADD) || (cmd_r == CMD_MUL)) && av_r && bv_r;
  assign sts.is_add   = (cmd_r == CMD_ADD);
  assign sts.gcd_done = (gp_r == '0) || (gq_r == '0);

  always_comb begin
    mop_a = ad_r;
    mop_b = bd_r;
    case (ctl.mul_step)
      MS_NUM: begin
        mop_a = an_r;
        mop_b = sts.is_add ? bd_r : bn_r;
      end
      MS_DEN: begin
        mop_a = ad_r;
        mop_b = bd_r;
      end
      MS_CROSS: begin
        mop_a = ad_r;
        mop_b = bn_r;
      end
      default: begin
        mop_a = ad_r;
        mop_b = bd_r;
      end
    endcase
  end

  assign prod = {{PW{1'b0}}, mop_a} * {{PW{1'b0}}, mop_b};

  always_comb begin
    gp_nxt = gp_r;
    gq_nxt = gq_r;
    gk_nxt = gk_r;
    if (!gp_r[0] && !gq_r[0]) begin
      gp_nxt = gp_r >> 1;
      gq_nxt = gq_r >> 1;
      gk_nxt = gk_r + KW'(1);
    end else if (!gp_r[0]) begin
      gp_nxt = gp_r >> 1;
    end else if (!gq_r[0]) begin
      gq_nxt = gq_r >> 1;
    end else if (gp_r >= gq_r) begin
      gp_nxt = (gp_r - gq_r) >> 1;
    end else begin
      gq_nxt = (gq_r - gp_r) >> 1;
    end
  end

  assign g_val = (gp_r | gq_r) << gk_r;

  assign ta    = {ra_r, qa_r[PW-1]};
  assign td    = {rd_r, qd_r[PW-1]};
  assign bit_a = (ta >= {1'b0, dv_r});
  assign bit_d = (td >= {1'b0, dv_r});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      an_r  <= in_a_num;
      ad_r  <= in_a_den;
      av_r  <= in_a_valid;
      bn_r  <= in_b_num;
      bd_r  <= in_b_den;
      bv_r  <= in_b_valid;
    end

    if (ctl.mul_en) begin
      case (ctl.mul_step)
        MS_NUM:   acc_num_r <= {1'b0, prod};
        MS_DEN:   acc_den_r <= prod;
        MS_CROSS: acc_num_r <= acc_num_r + {1'b0, prod};
        default:  acc_den_r <= prod;
      endcase
    end

    if (ctl.gcd_init) begin
      // A zero numerator is given a divisor of one.
      gp_r <= an_r;
      gq_r <= (an_r == '0) ? PW'(1) : ad_r;
      gk_r <= '0;
    end else if (ctl.gcd_step) begin
      gp_r <= gp_nxt;
      gq_r <= gq_nxt;
      gk_r <= gk_nxt;
    end

    if (ctl.div_init) begin
      dv_r <= g_val;
      qa_r <= an_r;
      qd_r <= ad_r;
      ra_r <= '0;
      rd_r <= '0;
    end else if (ctl.div_step) begin
      ra_r <= bit_a ? PW'(ta - {1'b0, dv_r}) : ta[PW-1:0];
      rd_r <= bit_d ? PW'(td - {1'b0, dv_r}) : td[PW-1:0];
      qa_r <= {qa_r[PW-2:0], bit_a};
      qd_r <= {qd_r[PW-2:0], bit_d};
    end

    if (ctl.publish) begin
      case (ctl.res_sel)
        RS_ACC: begin
          res_num_r   <= acc_num_r;
          res_den_r   <= acc_den_r;
          res_valid_r <= 1'b1;
        end
        RS_QUO: begin
          res_num_r   <= {{(PW+1){1'b0}}, qa_r};
          res_den_r   <= {{PW{1'b0}}, qd_r};
          res_valid_r <= 1'b1;
        end
        default: begin
          res_num_r   <= '0;
          res_den_r   <= '0;
          res_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_res_num   = res_num_r;
  assign out_res_den   = res_den_r;
  assign out_res_valid = res_valid_r;

endmodule

`default_nettype wire

/* design/fram_ctrl.sv */
// ----------------------------------------------------------------------------
// Fraction unit controller
// Sequences one command at a time through the datapath and owns both
// channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fram_ctrl import fram_pkg::*; #(
  parameter int unsigned PW = PART_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire fram_sts_t sts,
  output fram_ctl_t      ctl
);

  localparam int unsigned CW = $clog2(PW);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_GCD    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_RESULT = 6'b100000
  } fram_state_t;

  fram_state_t state_r, state_nxt;
  fram_mstep_t mstep_r, mstep_nxt;
  fram_rsel_t  rsel_r, rsel_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    mstep_nxt     = mstep_r;
    rsel_nxt      = rsel_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    ctl.mul_step  = mstep_r;
    ctl.res_sel   = rsel_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.make_ok) begin
          ctl.gcd_init = 1'b1;
          state_nxt    = ST_GCD;
        end else if (sts.arith_ok) begin
          mstep_nxt = MS_NUM;
          state_nxt = ST_MUL;
        end else begin
          rsel_nxt  = RS_ZERO;
          state_nxt = ST_RESULT;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        case (mstep_r)
          MS_NUM: mstep_nxt = MS_DEN;
          MS_DEN: begin
            if (sts.is_add) begin
              mstep_nxt = MS_CROSS;
            end else begin
              rsel_nxt  = RS_ACC;
              state_nxt = ST_RESULT;
            end
          end
          default: begin
            rsel_nxt  = RS_ACC;
            state_nxt = ST_RESULT;
          end
        endcase
      end
      ST_GCD: begin
        if (sts.gcd_done) begin
          ctl.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          ctl.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          rsel_nxt  = RS_QUO;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          ctl.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= MS_NUM;
      rsel_r      <= RS_ZERO;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      rsel_r      <= rsel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("Accepted transaction was not decoded in the next cycle.");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.publish |-> (state_r == ST_RESULT) && out_free)
    else $error("Result written while the output register was occupied.");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CW'(PW - 1)) |=> (state_r == ST_RESULT))
    else $error("Division did not end after the full number of steps.");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("Output became valid outside the result state.");
`endif

endmodule

`default_nettype wire

/* test/tb_fraction_reduce_add_multiply.sv */
// ----------------------------------------------------------------------------
// Testbench for the fraction reduce, add and multiply unit
// Drives make, add, multiply and unused commands through the input channel
// under random idle gaps and result stalls. Every result transaction is
// checked, field by field and in order, against fractions worked out here
// from each accepted command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fraction_reduce_add_multiply;
  import fram_pkg::*;

  localparam int unsigned PW         = PART_WIDTH_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN      = 64;

  typedef struct {
    fram_cmd_code_t command;
    logic [PW-1:0]  a_num;
    logic [PW-1:0]  a_den;
    logic           a_valid;
    logic [PW-1:0]  b_num;
    logic [PW-1:0]  b_den;
    logic           b_valid;
  } frac_cmd_t;

  typedef struct {
    logic [2*PW:0]   num;
    logic [2*PW-1:0] den;
    logic            ok;
  } frac_res_t;

  class fraction_board;
    frac_res_t awaited_fractions[$];
    int        errors;
    int        n_make, n_add, n_mul, n_unused;
    int        n_checked, n_invalid;

    function new();
      errors    = 0;
      n_make    = 0;
      n_add     = 0;
      n_mul     = 0;
      n_unused  = 0;
      n_checked = 0;
      n_invalid = 0;
    endfunction

    function logic [PW-1:0] common_factor(logic [PW-1:0] p, logic [PW-1:0] q);
      logic [PW-1:0] t;
      if (p == 0 || q == 0) return PW'(1);
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      return p;
    endfunction

    function frac_res_t predict_fraction(frac_cmd_t c);
      frac_res_t     r;
      logic [2*PW:0] an, ad, bn, bd;
      logic [PW-1:0] g;
      r.num = '0;
      r.den = '0;
      r.ok  = 1'b0;
      an = (2*PW+1)'(c.a_num);
      ad = (2*PW+1)'(c.a_den);
      bn = (2*PW+1)'(c.b_num);
      bd = (2*PW+1)'(c.b_den);
      case (c.command)
        CMD_MAKE: begin
          if (c.a_valid && c.a_den != 0) begin
            g     = common_factor(c.a_num, c.a_den);
            r.num = (2*PW+1)'(c.a_num / g);
            r.den = (2*PW)'(c.a_den / g);
            r.ok  = 1'b1;
          end
        end
        CMD_ADD: begin
          if (c.a_valid && c.b_valid) begin
            r.num = an * bd + ad * bn;
            r.den = (2*PW)'(ad * bd);
            r.ok  = 1'b1;
          end
        end
        CMD_MUL: begin
          if (c.a_valid && c.b_valid) begin
            r.num = an * bn;
            r.den = (2*PW)'(ad * bd);
            r.ok  = 1'b1;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_command(frac_cmd_t c);
      case (c.command)
        CMD_MAKE: n_make++;
        CMD_ADD:  n_add++;
        CMD_MUL:  n_mul++;
        default:  n_unused++;
      endcase
      awaited_fractions.push_back(predict_fraction(c));
    endfunction

    function void check_result(logic [2*PW:0] num, logic [2*PW-1:0] den, logic ok);
      frac_res_t e;
      if (awaited_fractions.size() == 0) begin
        $error("result transaction arrived with no prediction pending");
        errors++;
        return;
      end
      e = awaited_fractions.pop_front();
      n_checked++;
      if (!e.ok) n_invalid++;
      if (num !== e.num) begin
        $error("res_num: expected %0d, got %0d", e.num, num);
        errors++;
      end
      if (den !== e.den) begin
        $error("res_den: expected %0d, got %0d", e.den, den);
        errors++;
      end
      if (ok !== e.ok) begin
        $error("res_valid: expected %0d, got %0d", e.ok, ok);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_fractions.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic steady;
  int   idle_cycles;

  fraction_board board;

  fram_in_if  #(.PW(PW)) in_ch ();
  fram_out_if #(.PW(PW)) out_ch ();

  fraction_reduce_add_multiply #(.PART_WIDTH(PW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic frac_cmd_t make_cmd(fram_cmd_code_t c,
                                         logic [PW-1:0] an, logic [PW-1:0] ad, logic av,
                                         logic [PW-1:0] bn, logic [PW-1:0] bd, logic bv);
    frac_cmd_t x;
    x.command = c;
    x.a_num   = an;
    x.a_den   = ad;
    x.a_valid = av;
    x.b_num   = bn;
    x.b_den   = bd;
    x.b_valid = bv;
    return x;
  endfunction

  function automatic logic [PW-1:0] random_part();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PW'($urandom_range(1, 255));
      5:       return PW'(1) << $urandom_range(0, PW-1);
      default: return PW'($urandom);
    endcase
  endfunction

  function automatic frac_cmd_t random_cmd();
    frac_cmd_t     x;
    int            pick;
    logic [PW-1:0] k;
    pick = $urandom_range(0, 19);
    if (pick <= 6)       x.command = CMD_MAKE;
    else if (pick <= 12) x.command = CMD_ADD;
    else if (pick <= 18) x.command = CMD_MUL;
    else                 x.command = CMD_NONE;
    x.a_num   = random_part();
    x.a_den   = random_part();
    x.b_num   = random_part();
    x.b_den   = random_part();
    x.a_valid = ($urandom_range(0, 7) != 0);
    x.b_valid = ($urandom_range(0, 7) != 0);
    // Fractions built on a shared factor give the reduction real work to do.
    if (x.command == CMD_MAKE && $urandom_range(0, 1) == 1) begin
      k       = PW'($urandom_range(1, 255));
      x.a_num = PW'($urandom_range(0, 255)) * k;
      x.a_den = PW'($urandom_range(1, 255)) * k;
    end
    return x;
  endfunction

  task automatic send_cmd(input frac_cmd_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command <= c.command;
    in_ch.a_num   <= c.a_num;
    in_ch.a_den   <= c.a_den;
    in_ch.a_valid <= c.a_valid;
    in_ch.b_num   <= c.b_num;
    in_ch.b_den   <= c.b_den;
    in_ch.b_valid <= c.b_valid;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    board.note_command(c);
    @(negedge clk);
  endtask

  task automatic drain_results();
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.res_num, out_ch.res_den, out_ch.res_valid);
        hold = steady ? 0 : $urandom_range(0, 3);
      end
    end
  endtask

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_fraction_reduce_add_multiply: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    board         = new();
    idle_cycles   = 0;
    steady        = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_MAKE;
    in_ch.a_num   = '0;
    in_ch.a_den   = '0;
    in_ch.a_valid = 1'b0;
    in_ch.b_num   = '0;
    in_ch.b_den   = '0;
    in_ch.b_valid = 1'b0;
    out_ch.ready  = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    send_cmd(make_cmd(CMD_MAKE, 0, 5, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 6, 4, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 48, 18, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1));
    send_cmd(make_cmd(CMD_MAKE, 16'hFFFF, 1, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 1, 16'hFFFF, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 16'h8000, 16'h4000, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 12, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 0, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 7, 3, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_MAKE, 65521, 65519, 1, 16'h1234, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 1, 2, 1, 1, 3, 1));
    send_cmd(make_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1));
    send_cmd(make_cmd(CMD_ADD, 5, 7, 0, 2, 3, 1));
    send_cmd(make_cmd(CMD_ADD, 5, 7, 1, 2, 3, 0));
    send_cmd(make_cmd(CMD_ADD, 3, 0, 1, 5, 7, 1));
    send_cmd(make_cmd(CMD_ADD, 0, 1, 1, 0, 1, 1));
    send_cmd(make_cmd(CMD_MUL, 2, 3, 1, 4, 5, 1));
    send_cmd(make_cmd(CMD_MUL, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1));
    send_cmd(make_cmd(CMD_MUL, 9, 4, 0, 3, 2, 1));
    send_cmd(make_cmd(CMD_MUL, 9, 4, 1, 3, 2, 0));
    send_cmd(make_cmd(CMD_MUL, 5, 0, 1, 0, 0, 1));
    send_cmd(make_cmd(CMD_NONE, 3, 4, 1, 5, 6, 1));
    send_cmd(make_cmd(CMD_NONE, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1));

    for (int blk = 0; blk < 17; blk++) begin
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) send_cmd(random_cmd());
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d make, %0d add, %0d multiply and %0d unused-code transactions.",
             board.n_make, board.n_add, board.n_mul, board.n_unused);
    $display("Checked %0d results, %0d of them invalid fractions.",
             board.n_checked, board.n_invalid);
    if (board.errors == 0) begin
      $display("tb_fraction_reduce_add_multiply: done, clean");
    end else begin
      $display("tb_fraction_reduce_add_multiply: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fram_pkg.sv
design/fram_in_if.sv
design/fram_out_if.sv
design/fram_dp.sv
design/fram_ctrl.sv
design/fraction_reduce_add_multiply.sv
test/tb_fraction_reduce_add_multiply.sv
